// ===== hw/rtl/dbed_pkg.sv =====
// package for the debounced button event detector
// register indexes, widths, reset values, button modes and event codes; no dependencies
package dbed_pkg;

    // configuration register indexes
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_DELAY = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MODE  = 1'd1;

    // widths of registers and fields
    localparam int unsigned DelayW = 16;
    localparam int unsigned ModeW  = 2;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned EventW = 3;

    // reset value of the delay configuration register
    localparam logic [DelayW-1:0] DELAY_RST = 16'd50;

    // button modes
    localparam logic [ModeW-1:0] MODE_CLICK     = 2'd0;
    localparam logic [ModeW-1:0] MODE_PUSH_PULL = 2'd1;
    localparam logic [ModeW-1:0] MODE_TOGGLE    = 2'd2;

    // event codes
    localparam logic [EventW-1:0] EVT_NONE   = 3'd0;
    localparam logic [EventW-1:0] EVT_CLICK  = 3'd1;
    localparam logic [EventW-1:0] EVT_PUSH   = 3'd2;
    localparam logic [EventW-1:0] EVT_PULL   = 3'd3;
    localparam logic [EventW-1:0] EVT_TOGGLE = 3'd4;

    typedef logic [TimeW-1:0] t_time;

endpackage

// ===== hw/rtl/dbed_in_if.sv =====
// poll channel of the debounced button event detector
// valid/ready handshake carrying raw pin level and timestamp; uses dbed_pkg
interface dbed_in_if import dbed_pkg::*; ;
    logic  valid;
    logic  ready;
    logic  raw_level;
    t_time now_ms;

    modport source (output valid, output raw_level, output now_ms, input ready);
    modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

// ===== hw/rtl/dbed_out_if.sv =====
// result channel of the debounced button event detector
// valid/ready handshake carrying event code, toggle and pressed; uses dbed_pkg
interface dbed_out_if import dbed_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [EventW-1:0] event_code;
    logic              toggle_level;
    logic              pressed;

    modport source (output valid, output event_code, output toggle_level,
                    output pressed, input ready);
    modport sink   (input valid, input event_code, input toggle_level,
                    input pressed, output ready);
endinterface

// ===== hw/rtl/debounced_button_event_detector.sv =====
// Debounced button event detector. Each poll item (raw pin level of an
// active-low button, millisecond timestamp) gives exactly one result item.
// Polls are registered on entry, then combinational logic updates the debounce
// state and loads the result register, so one item is taken every clock while
// the result side does not stall. Back-pressure on the result side stalls the
// input register and then the input channel. Any raw level change restarts the
// debounce timer; the level is accepted once the wrapping elapsed time is
// strictly above the configured delay.
// Configuration writes are only to be made while no item is in flight.
// Depends on dbed_pkg, dbed_in_if and dbed_out_if.
module debounced_button_event_detector
    import dbed_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    dbed_in_if.sink            i_in,
    dbed_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data
);

    // configuration registers
    logic [DelayW-1:0] r_delay;
    logic [ModeW-1:0]  r_mode;

    // input register
    logic  r_s1_valid;
    logic  r_s1_raw;
    t_time r_s1_now;

    // debounce state
    logic  r_prev_raw;
    t_time r_last_change;
    logic  r_deb_level;
    logic  r_prev_pressed;
    logic  r_toggle;

    // result register
    logic              r_out_valid;
    logic [EventW-1:0] r_out_event;
    logic              r_out_pressed;

    // next values
    t_time             n_last_change;
    t_time             elapsed;
    logic              n_deb_level;
    logic              n_pressed;
    logic              n_toggle;
    logic [EventW-1:0] n_event;
    logic              rise;
    logic              fall;
    logic              out_free;
    logic              s1_adv;
    logic              in_acc;

    // handshake control
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_acc   = i_in.valid && i_in.ready;

    // debounce and edge detection
    always_comb begin
        n_last_change = (r_s1_raw != r_prev_raw) ? r_s1_now : r_last_change;
        elapsed       = r_s1_now - n_last_change;
        n_deb_level   = (elapsed > {{(TimeW-DelayW){1'b0}}, r_delay}) ? r_s1_raw
                                                                      : r_deb_level;
        n_pressed     = !n_deb_level;
        rise          = n_pressed && !r_prev_pressed;
        fall          = !n_pressed && r_prev_pressed;
        n_toggle      = r_toggle;
        n_event       = EVT_NONE;
        case (r_mode)
            MODE_CLICK: begin
                if (rise) n_event = EVT_CLICK;
            end
            MODE_PUSH_PULL: begin
                if (rise)      n_event = EVT_PUSH;
                else if (fall) n_event = EVT_PULL;
            end
            MODE_TOGGLE: begin
                if (rise) begin
                    n_event  = EVT_TOGGLE;
                    n_toggle = !r_toggle;
                end
            end
            default: begin
                n_event = EVT_NONE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RST;
            r_mode  <= MODE_CLICK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY: r_delay <= i_cfg_data[DelayW-1:0];
                CFG_MODE:  r_mode  <= i_cfg_data[ModeW-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (in_acc) begin
            r_s1_raw <= i_in.raw_level;
            r_s1_now <= i_in.now_ms;
        end
    end

    // debounce state, updated as an item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw     <= 1'b0;
            r_last_change  <= '0;
            r_deb_level    <= 1'b0;
            r_prev_pressed <= 1'b1;
            r_toggle       <= 1'b0;
        end else if (s1_adv) begin
            r_prev_raw     <= r_s1_raw;
            r_last_change  <= n_last_change;
            r_deb_level    <= n_deb_level;
            r_prev_pressed <= n_pressed;
            r_toggle       <= n_toggle;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv) begin
            r_out_event   <= n_event;
            r_out_pressed <= n_pressed;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_code   = r_out_event;
    assign o_out.toggle_level = r_toggle;
    assign o_out.pressed      = r_out_pressed;

`ifndef SYNTHESIS
    // press events only come with pressed high, pull only with pressed low
    a_event_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_event == EVT_CLICK || r_out_event == EVT_PUSH ||
                         r_out_event == EVT_TOGGLE)) |-> r_out_pressed)
        else $error("press event without pressed");

    a_pull_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EVT_PULL) |-> !r_out_pressed)
        else $error("pull event while pressed");

    // the toggle bit only flips together with a toggle event
    a_toggle_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_toggle != $past(r_toggle))
            |-> (r_out_valid && r_out_event == EVT_TOGGLE))
        else $error("toggle bit changed without toggle event");

    // a stalled item in the input register is kept
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_now)))
        else $error("input register lost a stalled item");
`endif

endmodule
